// ===== design/client_priority_arbiter_core_assert.svh =====
// Assertion macros shared by the client priority arbiter RTL.
`ifndef CLIENT_PRIORITY_ARBITER_CORE_ASSERT_SVH
`define CLIENT_PRIORITY_ARBITER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge and held off in reset.
`define CPA_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and held off in reset.
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cpa_pkg.sv =====
// Constants and types shared by the client priority arbiter files.
package cpa_pkg;

   localparam int MAX_CLIENTS = 64;
   localparam int SLOT_W      = $clog2(MAX_CLIENTS);
   localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);

   localparam int ACT_W    = 3;
   localparam int CLIENT_W = 6;
   localparam int PRIO_W   = 16;
   localparam int ORD_W    = 7;

   // The rank counter must reach two past the slot count.
   localparam int RANK_W = $clog2(MAX_CLIENTS + 3);
   localparam int CMP_W  = (RANK_W > ORD_W) ? RANK_W : ORD_W;

   localparam logic [ORD_W-1:0] ORDER_MAX = '1;

   typedef enum logic [ACT_W-1:0] {
      ACT_CONNECT    = 3'd0,
      ACT_DISCONNECT = 3'd1,
      ACT_REGISTER   = 3'd2,
      ACT_STREAM     = 3'd3,
      ACT_QUERY      = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DUP,
      ST_RANK,
      ST_ORDER_WR,
      ST_FINISH_REG,
      ST_QRY_READ,
      ST_QRY_LOAD,
      ST_QRY_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== design/cpa_req_if.sv =====
// Request channel interface of the client priority arbiter.
interface cpa_req_if
   import cpa_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ACT_W-1:0]    action;
   logic [CLIENT_W-1:0] client;
   logic [PRIO_W-1:0]   priority_value;
   logic                streaming_only;

   modport source (output valid, action, client, priority_value, streaming_only,
                   input  ready);
   modport sink   (input  valid, action, client, priority_value, streaming_only,
                   output ready);
endinterface

// ===== design/cpa_rsp_if.sv =====
// Response channel interface of the client priority arbiter.
interface cpa_rsp_if
   import cpa_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             ok;
   logic [ORD_W-1:0] assigned_order;

   modport source (output valid, ok, assigned_order, input  ready);
   modport sink   (input  valid, ok, assigned_order, output ready);
endinterface

// ===== design/client_priority_arbiter_core.sv =====
// Client priority arbiter: slot table, register with order compaction, control query.
//
//   Channel | Dir | Transfer content
//   --------+-----+-----------------------------------------------------------
//   req     | in  | action, client, priority_value, streaming_only
//   rsp     | out | ok, assigned_order
//
// Connect, disconnect and start-stream pass through the execute and done states before the response is registered.
// A query reads the requester's entry, then walks the table one slot per cycle and answers
// when an entry denies it or the walk ends. A register walks the table for the duplicate
// check and then once per compacted rank, writing each picked slot's new order after its pass.
// The single read port of the priority and order memories is why the table is walked slot by
// slot. Reset is synchronous and clears the slot flags; no clearing pass is needed.
// The request side takes a new transfer while an earlier response still waits downstream.

`include "client_priority_arbiter_core_assert.svh"

module client_priority_arbiter_core
   import cpa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   cpa_req_if.sink   req,
   cpa_rsp_if.source rsp
);

   // Per-slot flags live in flip-flops so that reset clears them at once. The
   // written flag marks priority and order entries that hold real data; an
   // entry never written reads as zero, which is its reset value.
   logic [MAX_CLIENTS-1:0] conn_ff, conn_in;
   logic [MAX_CLIENTS-1:0] strm_ff, strm_in;
   logic [MAX_CLIENTS-1:0] written_ff, written_in;

   // Priority and arrival order tables, one write and one read per cycle.
   logic [PRIO_W-1:0] prio_mem  [MAX_CLIENTS];
   logic [ORD_W-1:0]  order_mem [MAX_CLIENTS];
   logic [PRIO_W-1:0] prio_q_ff;
   logic [ORD_W-1:0]  order_q_ff;

   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              cvalid_ff, cvalid_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic              so_ff, so_in;
   logic [ORD_W-1:0]  my_order_ff, my_order_in;

   // Compaction state: current rank and the best candidate found in this pass.
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [ORD_W:0]    best_ff, best_in;
   logic [SLOT_W-1:0] pick_ff, pick_in;
   logic              pick_vld_ff, pick_vld_in;

   // Table walk: issue counter and the stage that lines up with the read data.
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0] rd_idx_ff;
   logic              rd_conn_ff, rd_strm_ff, rd_wr_ff;

   logic              res_ok_ff, res_ok_in;
   logic [ORD_W-1:0]  res_order_ff, res_order_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [ORD_W-1:0]  rsp_order_ff, rsp_order_in;

   logic              issue;
   logic [SLOT_W-1:0] rd_addr;
   logic              we_prio, we_order;
   logic [SLOT_W-1:0] wr_addr;
   logic [PRIO_W-1:0] wr_prio;
   logic [ORD_W-1:0]  wr_order;

   logic [PRIO_W-1:0] e_prio;
   logic [ORD_W-1:0]  e_order;
   logic              scan_more, scan_done;
   logic              counted, deny, earliest;
   logic [7:0]        e_byte, my_byte;

   function automatic logic [ORD_W-1:0] sat_order(input logic [RANK_W-1:0] r);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(r);
      if (wide > CMP_W'(ORDER_MAX)) return ORDER_MAX;
      return ORD_W'(r);
   endfunction

   assign e_prio    = rd_wr_ff ? prio_q_ff  : '0;
   assign e_order   = rd_wr_ff ? order_q_ff : '0;
   assign scan_more = (scan_ff < CNT_W'(MAX_CLIENTS));
   assign scan_done = !scan_more && !rd_vld_ff;

   // Query compare: upper byte ranks, bit 8 of the requester's priority picks
   // whether the earlier or the later arrival wins a tie.
   assign e_byte   = e_prio[PRIO_W-1:8];
   assign my_byte  = prio_ff[PRIO_W-1:8];
   assign earliest = prio_ff[8];
   assign counted  = rd_vld_ff && rd_conn_ff && (!so_ff || rd_strm_ff);
   assign deny     = counted && ((e_byte > my_byte) ||
                                 ((e_byte == my_byte) &&
                                  (earliest ? (e_order < my_order_ff)
                                            : (e_order > my_order_ff))));

   assign req.ready          = (state_ff == ST_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.ok             = rsp_ok_ff;
   assign rsp.assigned_order = rsp_order_ff;

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      slot_in      = slot_ff;
      cvalid_in    = cvalid_ff;
      prio_in      = prio_ff;
      so_in        = so_ff;
      my_order_in  = my_order_ff;
      rank_in      = rank_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      pick_vld_in  = pick_vld_ff;
      scan_in      = scan_ff;
      conn_in      = conn_ff;
      strm_in      = strm_ff;
      written_in   = written_ff;
      res_ok_in    = res_ok_ff;
      res_order_in = res_order_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_order_in = rsp_order_ff;
      issue        = 1'b0;
      rd_addr      = scan_ff[SLOT_W-1:0];
      we_prio      = 1'b0;
      we_order     = 1'b0;
      wr_addr      = slot_ff;
      wr_prio      = '0;
      wr_order     = '0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               act_in       = action_type'(req.action);
               slot_in      = SLOT_W'(req.client);
               cvalid_in    = (int'(req.client) < MAX_CLIENTS);
               prio_in      = req.priority_value;
               so_in        = req.streaming_only;
               scan_in      = '0;
               res_ok_in    = 1'b1;
               res_order_in = '0;
               if (action_type'(req.action) == ACT_REGISTER) begin
                  if (int'(req.client) < MAX_CLIENTS) begin
                     state_in = ST_DUP;
                  end else begin
                     res_ok_in = 1'b0;
                     state_in  = ST_DONE;
                  end
               end else if (action_type'(req.action) == ACT_QUERY) begin
                  if (int'(req.client) < MAX_CLIENTS) begin
                     state_in = ST_QRY_READ;
                  end else begin
                     res_ok_in = 1'b0;
                     state_in  = ST_DONE;
                  end
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            if (cvalid_ff) begin
               unique case (act_ff)
                  ACT_CONNECT: begin
                     conn_in[slot_ff]    = 1'b1;
                     strm_in[slot_ff]    = 1'b0;
                     written_in[slot_ff] = 1'b1;
                     we_prio             = 1'b1;
                     we_order            = 1'b1;
                  end
                  ACT_DISCONNECT: begin
                     conn_in[slot_ff] = 1'b0;
                  end
                  ACT_STREAM: begin
                     strm_in[slot_ff] = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            state_in = ST_DONE;
         end

         // Any connected slot holding the requested priority fails the register.
         ST_DUP: begin
            issue = scan_more;
            if (scan_more) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (rd_vld_ff && rd_conn_ff && (e_prio == prio_ff)) begin
               res_ok_in    = 1'b0;
               res_order_in = '0;
               state_in     = ST_DONE;
            end else if (scan_done) begin
               rank_in     = RANK_W'(1);
               scan_in     = '0;
               best_in     = '1;
               pick_vld_in = 1'b0;
               state_in    = ST_RANK;
            end
         end

         // One pass per rank: find the lowest order at or above the rank,
         // first slot index winning among equals.
         ST_RANK: begin
            issue = scan_more;
            if (scan_more) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (rd_vld_ff && rd_conn_ff &&
                (CMP_W'(e_order) >= CMP_W'(rank_ff)) &&
                ({1'b0, e_order} < best_ff)) begin
               best_in     = {1'b0, e_order};
               pick_in     = rd_idx_ff;
               pick_vld_in = 1'b1;
            end
            if (scan_done) begin
               state_in = pick_vld_ff ? ST_ORDER_WR : ST_FINISH_REG;
            end
         end

         ST_ORDER_WR: begin
            we_order = 1'b1;
            wr_addr  = pick_ff;
            wr_order = sat_order(rank_ff);
            rank_in  = rank_ff + RANK_W'(1);
            if (rank_ff == RANK_W'(MAX_CLIENTS + 1)) begin
               state_in = ST_FINISH_REG;
            end else begin
               scan_in     = '0;
               best_in     = '1;
               pick_vld_in = 1'b0;
               state_in    = ST_RANK;
            end
         end

         ST_FINISH_REG: begin
            we_prio             = 1'b1;
            we_order            = 1'b1;
            wr_prio             = prio_ff;
            wr_order            = sat_order(rank_ff);
            written_in[slot_ff] = 1'b1;
            res_ok_in           = 1'b1;
            res_order_in        = sat_order(rank_ff);
            state_in            = ST_DONE;
         end

         ST_QRY_READ: begin
            rd_addr  = slot_ff;
            state_in = ST_QRY_LOAD;
         end

         // The requester's own entry becomes the reference for the walk.
         ST_QRY_LOAD: begin
            prio_in     = e_prio;
            my_order_in = e_order;
            scan_in     = '0;
            state_in    = ST_QRY_SCAN;
         end

         ST_QRY_SCAN: begin
            issue = scan_more;
            if (scan_more) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (deny) begin
               res_ok_in = 1'b0;
               state_in  = ST_DONE;
            end else if (scan_done) begin
               res_ok_in = 1'b1;
               state_in  = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_order_in = res_order_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_vld_in = issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         conn_ff      <= '0;
         strm_ff      <= '0;
         written_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         pick_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         conn_ff      <= conn_in;
         strm_ff      <= strm_in;
         written_ff   <= written_in;
         rd_vld_ff    <= rd_vld_in;
         pick_vld_ff  <= pick_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      slot_ff      <= slot_in;
      cvalid_ff    <= cvalid_in;
      prio_ff      <= prio_in;
      so_ff        <= so_in;
      my_order_ff  <= my_order_in;
      rank_ff      <= rank_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      scan_ff      <= scan_in;
      res_ok_ff    <= res_ok_in;
      res_order_ff <= res_order_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_order_ff <= rsp_order_in;
      rd_idx_ff    <= rd_addr;
      rd_conn_ff   <= conn_ff[rd_addr];
      rd_strm_ff   <= strm_ff[rd_addr];
      rd_wr_ff     <= written_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we_prio) begin
         prio_mem[wr_addr] <= wr_prio;
      end
      if (we_order) begin
         order_mem[wr_addr] <= wr_order;
      end
      prio_q_ff  <= prio_mem[rd_addr];
      order_q_ff <= order_mem[rd_addr];
   end

   `CPA_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, !req.ready, "request taken but arbiter stayed idle")
   `CPA_ASSERT(a_write_not_idle, we_prio || we_order, state_ff != ST_IDLE, "table written while idle")
   `CPA_ASSERT(a_order_implies_ok, rsp.valid && (rsp.assigned_order != '0), rsp.ok, "order given with failed result")
   `CPA_ASSERT(a_compact_target, state_ff == ST_ORDER_WR, pick_vld_ff && conn_ff[pick_ff], "compaction writes a slot that is not connected")
   `CPA_ASSERT_NEXT(a_done_loads_rsp, (state_ff == ST_DONE) && (!rsp.valid || rsp.ready), rsp.valid && (rsp.ok == $past(res_ok_ff)), "finished result not presented")

endmodule
